// File: hw/rtl/pat_pkg.sv
// Shared types and constants for the parenthesis-aware tokenizer.
`default_nettype none
package pat_pkg;

   localparam int LEN_W  = 13;
   localparam int MASK_W = 64;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam logic [MASK_W-1:0] MASK_LOW_RST  = 64'h0000_0001_0000_3E00;
   localparam logic [MASK_W-1:0] MASK_HIGH_RST = 64'h0;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_OPEN  = 3'd2,
      ST_LONG  = 3'd3,
      ST_CLOSE = 3'd4
   } tok_status_type;

   typedef enum logic [1:0] {
      CSR_MASK_LOW  = 2'd0,
      CSR_MASK_HIGH = 2'd1,
      CSR_LIMIT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } pat_req_type;

   typedef struct packed {
      logic             is_token_end;
      logic [7:0]       out_byte;
      tok_status_type   token_status;
      logic [LEN_W-1:0] token_length;
   } pat_rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask_low;
      logic [MASK_W-1:0] mask_high;
      logic [LEN_W-1:0]  limit;
   } pat_cfg_type;

endpackage
`default_nettype wire

// File: hw/rtl/pat_if.sv
// Valid/ready channel interfaces for the tokenizer input and result streams.
`default_nettype none
interface pat_req_if import pat_pkg::*; ();
   logic        valid;
   logic        ready;
   pat_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pat_rsp_if import pat_pkg::*; ();
   logic        valid;
   logic        ready;
   pat_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pat_csr.sv
// Configuration registers: delimiter masks and token length limit.
`default_nettype none
module pat_csr import pat_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [MASK_W-1:0] csr_wdata,
   output pat_cfg_type            cfg
);

   pat_cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_LOW:  cfg_in.mask_low  = csr_wdata;
            CSR_MASK_HIGH: cfg_in.mask_high = csr_wdata;
            CSR_LIMIT:     cfg_in.limit     = csr_wdata[LEN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mask_low  <= MASK_LOW_RST;
         cfg_ff.mask_high <= MASK_HIGH_RST;
         cfg_ff.limit     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: hw/rtl/pat_core.sv
// Token state (depth, count, skip flag) and the per-byte decision logic.
`default_nettype none
module pat_core import pat_pkg::*; #(
   parameter int MAX_TOKEN = 4096,
   parameter int MAX_DEPTH = 255
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire pat_req_type  item,
   input  wire pat_cfg_type  cfg,
   output logic              res_valid,
   output pat_rsp_type       res
);

   localparam int CW = $clog2(MAX_TOKEN + 1);
   localparam int BW = (CW > LEN_W) ? CW : LEN_W;
   localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
   localparam logic [BW-1:0]        TOK_MAX = BW'(MAX_TOKEN);
   localparam logic signed [DW-1:0] DEP_MAX = DW'(MAX_DEPTH);
   localparam logic signed [DW-1:0] DEP_MIN = -DW'(MAX_DEPTH);

   logic signed [DW-1:0] depth_ff, depth_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 skip_ff, skip_in;

   logic          delim;
   logic [BW-1:0] limit_b, bound, count_b;
   logic          depth_nz;

   // delimiter lookup: bytes 128 and up are never delimiters
   always_comb begin
      priority if (item.in_byte[7])
         delim = 1'b0;
      else if (item.in_byte[6])
         delim = cfg.mask_high[item.in_byte[5:0]];
      else
         delim = cfg.mask_low[item.in_byte[5:0]];
   end

   // effective length bound
   assign limit_b  = BW'(cfg.limit);
   assign bound    = (cfg.limit != '0 && limit_b < TOK_MAX) ? limit_b : TOK_MAX;
   assign count_b  = BW'(count_ff);
   assign depth_nz = (depth_ff != '0);

   // per-item decision
   always_comb begin
      depth_in  = depth_ff;
      count_in  = count_ff;
      skip_in   = skip_ff;
      res_valid = 1'b0;
      res       = '0;
      res.token_status = ST_OK;
      priority if (item.end_of_input) begin
         res_valid        = 1'b1;
         res.is_token_end = 1'b1;
         res.token_status = (count_ff == '0) ? ST_EMPTY : (depth_nz ? ST_OPEN : ST_OK);
         res.token_length = count_b[LEN_W-1:0];
         depth_in = '0;
         count_in = '0;
         skip_in  = 1'b0;
      end else if (skip_ff && delim) begin
         skip_in = 1'b1;
      end else if (item.in_byte == CH_LPAREN) begin
         skip_in = 1'b0;
         if (depth_ff < DEP_MAX) depth_in = depth_ff + DW'(1);
      end else if (item.in_byte == CH_RPAREN) begin
         skip_in = 1'b0;
         if (depth_ff > DEP_MIN) depth_in = depth_ff - DW'(1);
      end else if (depth_ff[DW-1]) begin
         // close without matching open (depth is negative)
         res_valid        = 1'b1;
         res.is_token_end = 1'b1;
         res.token_status = ST_CLOSE;
         res.token_length = count_b[LEN_W-1:0];
         depth_in = '0;
         count_in = '0;
         skip_in  = 1'b0;
      end else if (item.in_byte == CH_NEWLINE && depth_nz) begin
         skip_in = 1'b0;
      end else if (delim) begin
         res_valid        = 1'b1;
         res.is_token_end = 1'b1;
         res.token_status = depth_nz ? ST_OPEN : ST_OK;
         res.token_length = count_b[LEN_W-1:0];
         depth_in = '0;
         count_in = '0;
         skip_in  = 1'b1;
      end else if (count_b >= bound) begin
         res_valid        = 1'b1;
         res.is_token_end = 1'b1;
         res.token_status = ST_LONG;
         res.token_length = bound[LEN_W-1:0];
         depth_in = '0;
         count_in = '0;
         skip_in  = 1'b0;
      end else begin
         res_valid    = 1'b1;
         res.out_byte = item.in_byte;
         count_in     = count_ff + CW'(1);
         skip_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         count_ff <= '0;
         skip_ff  <= 1'b0;
      end else if (fire) begin
         depth_ff <= depth_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/paren_aware_tokenizer.sv
// Top level of the parenthesis-aware tokenizer.
// Input items (req_ch) carry one byte or an end-of-input mark; result items
// (rsp_ch) carry either one token byte or a token end with status and length.
// Each input item gives zero or one result item: '(' and ')' are dropped, a
// newline inside parentheses is dropped, delimiters right after a token end
// made by a delimiter are skipped. Status codes: ok, empty at end, open paren
// unbalanced, too long, unbalanced close.
// The datapath is an input register, one stage of decode and counter logic,
// and a result register. A result is presented on rsp_ch once its item has
// passed the input register and been decoded into the result register;
// one item is accepted every cycle while the result side takes them, set by
// the single token state update per cycle.
// When rsp_ch.ready is low and the result register is full, the decode stage
// holds and req_ch.ready drops once the input register is also full.
// The csr port writes the delimiter masks and the length limit; write it only
// while no item is in flight. Synchronous reset clears token state, both
// pipeline registers and the configuration to its defaults (space, TAB, LF,
// VT, FF and CR as delimiters, no extra length limit).
`default_nettype none
module paren_aware_tokenizer import pat_pkg::*; #(
   parameter int MAX_TOKEN = 4096,
   parameter int MAX_DEPTH = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   pat_req_if.sink                req_ch,
   pat_rsp_if.source              rsp_ch,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [MASK_W-1:0] csr_wdata
);

   pat_cfg_type cfg;
   pat_req_type in_ff;
   logic        in_v_ff;
   pat_rsp_type out_ff, res;
   logic        out_v_ff, res_valid;
   logic        out_free, fire;

   pat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: decode advances when the result register can take a value
   assign out_free     = !out_v_ff || rsp_ch.ready;
   assign fire         = in_v_ff && out_free;
   assign req_ch.ready = !in_v_ff || fire;

   pat_core #(
      .MAX_TOKEN (MAX_TOKEN),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_v_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_ff <= req_ch.payload;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff <= fire && res_valid;
      end
      if (fire && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.payload = out_ff;

endmodule
`default_nettype wire
